@@ design/jacobi_heat_grid_solver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// jacobi heat grid solver assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef JACOBI_HEAT_GRID_SOLVER_UNIT_DEFINES_SVH
`define JACOBI_HEAT_GRID_SOLVER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define JHGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define JHGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define JHGS_ASSERT_IMP(lbl, ante, cons, msg)
`define JHGS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/jhgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhgs_pkg
// widths, defaults, register indexes and control types of the solver
// ----------------------------------------------------------------------------
package jhgs_pkg;

	localparam int GRID_SIZE_W    = 7;
	localparam int ITER_W         = 20;
	localparam int LOSS_W         = 24;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 24;
	localparam int MAX_GRID_DEF   = 64;
	localparam int FRAC_BITS_DEF  = 18;
	localparam int INT_BITS       = 6;
	localparam int MEASURE_PERIOD = 100;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCURACY  = 2'd2;

	localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
	localparam logic [ITER_W-1:0]      MAX_ITER_RST  = 20'd1000;
	localparam logic [LOSS_W-1:0]      ACCURACY_RST  = 24'd1;

	typedef struct packed {
		logic load;
		logic div_go;
		logic build_go;
		logic sweep_go;
		logic iter;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic build_done;
		logic sweep_done;
		logic stop;
		logic at_limit;
	} status_t;

endpackage

@@ design/jhgs_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhgs channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface jhgs_req_if;
	logic valid;
	logic ready;
	logic start_req;
	modport source (output valid, output start_req, input ready);
	modport sink (input valid, input start_req, output ready);
endinterface

interface jhgs_rsp_if
	import jhgs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [LOSS_W-1:0]   final_loss;
	logic [ITER_W-1:0]   iterations_done;
	modport source (output valid, output final_loss, output iterations_done, input ready);
	modport sink (input valid, input final_loss, input iterations_done, output ready);
endinterface

@@ design/jhgs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhgs_datapath
// step divider, grid builder, stencil sweep over ping-pong grid memory
// ----------------------------------------------------------------------------
module jhgs_datapath
	import jhgs_pkg::*;
#(
	parameter int MAX_GRID      = MAX_GRID_DEF,
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  logic [GRID_SIZE_W-1:0] grid_size,
	input  logic [ITER_W-1:0]      max_iterations,
	input  logic [LOSS_W-1:0]      accuracy_limit,
	output status_t                sts,
	output logic [LOSS_W-1:0]      final_loss,
	output logic [ITER_W-1:0]      iterations_done
);

	localparam int CW    = FRACTION_BITS + INT_BITS;
	localparam int NW    = GRID_SIZE_W;
	localparam int AW    = $clog2(MAX_GRID * MAX_GRID);
	localparam int DEPTH = 2 * MAX_GRID * MAX_GRID;
	localparam int DCW   = $clog2(CW + 1);
	localparam int CMPW  = (CW > LOSS_W) ? CW : LOSS_W;
	localparam int PW    = $clog2(MEASURE_PERIOD);
	localparam logic [CW-1:0] FX10 = CW'(10) << FRACTION_BITS;
	localparam logic [CW-1:0] FX20 = CW'(20) << FRACTION_BITS;
	localparam logic [CW-1:0] FX30 = CW'(30) << FRACTION_BITS;
	localparam logic [2:0] PH_LAST = 3'd5;

	logic [CW-1:0] mem [DEPTH];

	logic [NW-1:0] n_q;
	logic [NW-1:0] nm1, nm2;
	logic [NW-1:0] n_clamp;

	// divider
	logic          div_act_q, div_sel_q;
	logic [DCW-1:0] div_cnt_q;
	logic [CW-1:0] dd_q, quo_q;
	logic [NW-1:0] rem_q;
	logic [NW:0]   rem_sh;
	logic          rem_ge;
	logic [NW-1:0] rem_nx;
	logic [CW-1:0] quo_nx;
	logic [CW-1:0] top_q, left_q;

	// builder
	logic          bld_act_q, bld_bank_q;
	logic [NW-1:0] bx_q, by_q;
	logic [AW-1:0] bidx_q;
	logic [CW-1:0] tacc_q, bacc_q, lacc_q;
	logic [CW-1:0] bval;

	// sweep
	logic          swp_act_q;
	logic [2:0]    ph_q;
	logic [NW-1:0] sx_q, sy_q;
	logic [AW-1:0] c_q;
	logic [CW+1:0] sum_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] new_val, dlt;
	logic [CW-1:0] rmax_q;
	logic          cur_q;

	// iteration state
	logic [ITER_W-1:0] it_q;
	logic [PW-1:0]     per_q;
	logic [CW-1:0]     loss_q;
	logic              measure;

	logic              we;
	logic [AW:0]       waddr, raddr;
	logic [CW-1:0]     wdata;
	logic [AW-1:0]     ra_idx;
	logic [AW-1:0]     n_a;

	logic div_done_q, build_done_q, sweep_done_q;
	logic [LOSS_W-1:0] out_loss_q;
	logic [ITER_W-1:0] out_iter_q;

	always_comb begin
		if (grid_size < NW'(2))
			n_clamp = NW'(2);
		else if (int'(grid_size) > MAX_GRID)
			n_clamp = NW'(MAX_GRID);
		else
			n_clamp = grid_size;
	end

	assign nm1 = n_q - NW'(1);
	assign nm2 = n_q - NW'(2);
	assign n_a = AW'(n_q);

	assign rem_sh = {rem_q, dd_q[CW-1]};
	assign rem_ge = rem_sh >= {1'b0, nm1};
	assign rem_nx = rem_ge ? NW'(rem_sh - {1'b0, nm1}) : NW'(rem_sh);
	assign quo_nx = {quo_q[CW-2:0], rem_ge};

	// edge priority: top row, left column, bottom row, right column
	always_comb begin
		if (by_q == '0)
			bval = tacc_q;
		else if (bx_q == '0)
			bval = lacc_q;
		else if (by_q == nm1)
			bval = bacc_q;
		else if (bx_q == nm1)
			bval = FX20;
		else
			bval = '0;
	end

	always_comb begin
		unique case (ph_q)
			3'd0:    ra_idx = c_q - n_a;
			3'd1:    ra_idx = c_q + n_a;
			3'd2:    ra_idx = c_q - AW'(1);
			3'd3:    ra_idx = c_q + AW'(1);
			default: ra_idx = c_q;
		endcase
	end

	assign raddr   = {cur_q, ra_idx};
	assign new_val = CW'(sum_q >> 2);
	assign dlt     = (new_val > rd_q) ? (new_val - rd_q) : (rd_q - new_val);

	always_comb begin
		we    = 1'b0;
		waddr = {bld_bank_q, bidx_q};
		wdata = bval;
		if (bld_act_q) begin
			we = 1'b1;
		end else if (swp_act_q && ph_q == PH_LAST) begin
			we    = 1'b1;
			waddr = {~cur_q, c_q};
			wdata = new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign measure = (per_q == '0) ||
		(({1'b0, it_q} + (ITER_W+1)'(1)) == {1'b0, max_iterations});

	assign sts.div_done   = div_done_q;
	assign sts.build_done = build_done_q;
	assign sts.sweep_done = sweep_done_q;
	assign sts.stop       = measure && (CMPW'(rmax_q) <= CMPW'(accuracy_limit));
	assign sts.at_limit   = (it_q == max_iterations);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_act_q    <= 1'b0;
			bld_act_q    <= 1'b0;
			swp_act_q    <= 1'b0;
			div_done_q   <= 1'b0;
			build_done_q <= 1'b0;
			sweep_done_q <= 1'b0;
			it_q         <= '0;
			loss_q       <= '0;
			out_loss_q   <= '0;
			out_iter_q   <= '0;
		end else begin
			div_done_q   <= 1'b0;
			build_done_q <= 1'b0;
			sweep_done_q <= 1'b0;

			if (cmd.load) begin
				n_q    <= n_clamp;
				it_q   <= '0;
				per_q  <= '0;
				loss_q <= '0;
				cur_q  <= 1'b0;
			end

			// restoring divider, two quotients back to back
			if (cmd.div_go) begin
				div_act_q <= 1'b1;
				div_sel_q <= 1'b0;
				div_cnt_q <= DCW'(CW);
				dd_q      <= FX10;
				rem_q     <= '0;
				quo_q     <= '0;
			end else if (div_act_q) begin
				dd_q      <= {dd_q[CW-2:0], 1'b0};
				rem_q     <= rem_nx;
				quo_q     <= quo_nx;
				div_cnt_q <= div_cnt_q - DCW'(1);
				if (div_cnt_q == DCW'(1)) begin
					if (!div_sel_q) begin
						top_q     <= quo_nx;
						div_sel_q <= 1'b1;
						div_cnt_q <= DCW'(CW);
						dd_q      <= FX20;
						rem_q     <= '0;
						quo_q     <= '0;
					end else begin
						left_q     <= quo_nx;
						div_act_q  <= 1'b0;
						div_done_q <= 1'b1;
					end
				end
			end

			// grid fill, both banks row by row
			if (cmd.build_go) begin
				bld_act_q  <= 1'b1;
				bld_bank_q <= 1'b0;
				bx_q       <= '0;
				by_q       <= '0;
				bidx_q     <= '0;
				tacc_q     <= FX10;
				bacc_q     <= FX30;
				lacc_q     <= FX10;
			end else if (bld_act_q) begin
				bidx_q <= bidx_q + AW'(1);
				if (bx_q == nm1) begin
					bx_q   <= '0;
					tacc_q <= FX10;
					bacc_q <= FX30;
					if (by_q == nm1) begin
						by_q   <= '0;
						lacc_q <= FX10;
						bidx_q <= '0;
						if (bld_bank_q) begin
							bld_act_q    <= 1'b0;
							build_done_q <= 1'b1;
						end
						bld_bank_q <= 1'b1;
					end else begin
						by_q   <= by_q + NW'(1);
						lacc_q <= lacc_q + left_q;
					end
				end else begin
					bx_q   <= bx_q + NW'(1);
					tacc_q <= tacc_q + top_q;
					bacc_q <= bacc_q - top_q;
				end
			end

			// stencil sweep, five reads and a write-back per interior cell
			if (cmd.sweep_go) begin
				rmax_q <= '0;
				sx_q   <= NW'(1);
				sy_q   <= NW'(1);
				c_q    <= n_a + AW'(1);
				ph_q   <= '0;
				if (n_q == NW'(2))
					sweep_done_q <= 1'b1;
				else
					swp_act_q <= 1'b1;
			end else if (swp_act_q) begin
				if (ph_q == '0)
					sum_q <= '0;
				else if (ph_q != PH_LAST)
					sum_q <= sum_q + (CW+2)'(rd_q);
				if (ph_q == PH_LAST) begin
					ph_q <= '0;
					if (dlt > rmax_q)
						rmax_q <= dlt;
					if (sx_q == nm2) begin
						if (sy_q == nm2) begin
							swp_act_q    <= 1'b0;
							sweep_done_q <= 1'b1;
						end else begin
							sy_q <= sy_q + NW'(1);
							sx_q <= NW'(1);
							c_q  <= c_q + AW'(3);
						end
					end else begin
						sx_q <= sx_q + NW'(1);
						c_q  <= c_q + AW'(1);
					end
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end

			if (cmd.iter) begin
				if (measure)
					loss_q <= rmax_q;
				if (!sts.stop) begin
					it_q  <= it_q + ITER_W'(1);
					per_q <= (per_q == PW'(MEASURE_PERIOD - 1)) ? '0 : per_q + PW'(1);
					cur_q <= ~cur_q;
				end
			end

			if (cmd.emit) begin
				out_loss_q <= LOSS_W'(loss_q);
				out_iter_q <= it_q;
			end
		end
	end

	assign final_loss      = out_loss_q;
	assign iterations_done = out_iter_q;

endmodule

@@ design/jhgs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhgs_ctrl
// solve sequencer and response valid
// ----------------------------------------------------------------------------
`include "jacobi_heat_grid_solver_unit_defines.svh"
module jhgs_ctrl
	import jhgs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_start,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_BUILD, ST_CHECK, ST_SWEEP, ST_ITER,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	cmd_t   cmd_q;
	logic   emit_pend_q;

	assign in_ready  = (state_q == ST_IDLE) && !emit_pend_q;
	assign out_valid = out_valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
			emit_pend_q <= 1'b0;
		end else begin
			cmd_q <= '0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			// result registers load on the cycle after emit
			if (emit_pend_q) begin
				out_valid_q <= 1'b1;
				emit_pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready && in_start) begin
						cmd_q.load <= 1'b1;
						state_q    <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					cmd_q.div_go <= 1'b1;
					state_q      <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						cmd_q.build_go <= 1'b1;
						state_q        <= ST_BUILD;
					end
				end
				ST_BUILD: begin
					if (sts.build_done)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (sts.at_limit) begin
						state_q <= ST_FINISH;
					end else begin
						cmd_q.sweep_go <= 1'b1;
						state_q        <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (sts.sweep_done) begin
						cmd_q.iter <= 1'b1;
						state_q    <= ST_ITER;
					end
				end
				ST_ITER: begin
					state_q <= sts.stop ? ST_FINISH : ST_CHECK;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						cmd_q.emit  <= 1'b1;
						emit_pend_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`JHGS_ASSERT_IMP(a_emit_slot_free, emit_pend_q, !out_valid_q, "result overwritten")
	`JHGS_ASSERT_IMP(a_sweep_done_ctx, sts.sweep_done, state_q == ST_SWEEP, "stray sweep done")
	`JHGS_ASSERT_NXT(a_start_seq, in_valid && in_ready && in_start, state_q == ST_DIV_GO, "start lost")
	`JHGS_ASSERT_IMP(a_build_done_ctx, sts.build_done, state_q == ST_BUILD, "stray build done")

endmodule

@@ design/jacobi_heat_grid_solver_unit.sv @@
`timescale 1ns / 1ps
// sequence: the top and left step divisions, the fill of both grid banks, then per
// iteration a sweep of the interior cells plus bookkeeping, then the result hand-off
// the sweep rate is set by the single read port: five reads and a write-back per cell
// throughput: one solve at a time; the next request is taken once the result is handed off
// to the result register, which holds it until the response side takes it
// reset: asynchronous active low; registers return to 64, 1000 and 1; grid memory not cleared
// ----------------------------------------------------------------------------
// jacobi_heat_grid_solver_unit
// jacobi 5-point relaxation of a square heat grid, one result per start item
// ----------------------------------------------------------------------------
module jacobi_heat_grid_solver_unit
	import jhgs_pkg::*;
#(
	parameter int MAX_GRID      = MAX_GRID_DEF,
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	jhgs_req_if.sink              req,
	jhgs_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers; the user must write them only while the solver is idle, the block does not enforce it
	logic [GRID_SIZE_W-1:0] grid_size_q;
	logic [ITER_W-1:0]      max_iter_q;
	logic [LOSS_W-1:0]      accuracy_q;

	cmd_t    cmd;
	status_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_RST;
			max_iter_q  <= MAX_ITER_RST;
			accuracy_q  <= ACCURACY_RST;
		end else if (cfg_we) begin
			// index beyond the register list is ignored
			unique case (cfg_idx)
				REG_GRID_SIZE: grid_size_q <= cfg_data[GRID_SIZE_W-1:0];
				REG_MAX_ITER:  max_iter_q  <= cfg_data[ITER_W-1:0];
				REG_ACCURACY:  accuracy_q  <= cfg_data[LOSS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: start, step division, fill, sweep/check loop, result hand-off
	jhgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_start  (req.start_req),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: divider, edge builder, ping-pong grid memory, change tracking
	jhgs_datapath #(
		.MAX_GRID      (MAX_GRID),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.grid_size       (grid_size_q),
		.max_iterations  (max_iter_q),
		.accuracy_limit  (accuracy_q),
		.sts             (sts),
		.final_loss      (rsp.final_loss),
		.iterations_done (rsp.iterations_done)
	);

endmodule

@@ dv/tb_jacobi_heat_grid_solver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jacobi_heat_grid_solver_unit
// drives start items into the solver, predicts each solve with a behavioral
// jacobi relaxation at the block's fixed-point widths, and checks every result
// ----------------------------------------------------------------------------
module tb_jacobi_heat_grid_solver_unit;
	import jhgs_pkg::*;

	localparam int GRID_CAP   = MAX_GRID_DEF;
	localparam int FRAC       = FRAC_BITS_DEF;
	localparam longint CYCLE_LIMIT = 40_000_000;

	typedef struct {
		logic [LOSS_W-1:0] loss;
		logic [ITER_W-1:0] iters;
	} solve_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_GRID_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	jhgs_req_if req ();
	jhgs_rsp_if rsp ();

	jacobi_heat_grid_solver_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the solver registers
	logic [GRID_SIZE_W-1:0] size_reg = GRID_SIZE_RST;
	logic [ITER_W-1:0] iter_limit_reg = MAX_ITER_RST;
	logic [LOSS_W-1:0] accuracy_reg = ACCURACY_RST;

	// predictor grids, values kept wide so the four-neighbour sum never wraps
	longint unsigned grid_old[GRID_CAP*GRID_CAP];
	longint unsigned grid_new[GRID_CAP*GRID_CAP];

	solve_result_t pending_solves[$];
	int errors = 0;
	longint cycles = 0;
	int hold_ready = 0;

	initial begin
		req.valid = 1'b0;
		req.start_req = 1'b0;
		rsp.ready = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		else if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void put_edge(int unsigned idx, longint unsigned v);
		grid_old[idx] = v;
		grid_new[idx] = v;
	endfunction

	// one complete solve on the shadow registers
	function automatic solve_result_t run_relaxation();
		solve_result_t res;
		int unsigned n, i, y, x, it;
		longint unsigned step_top, step_left, s, a, b, dlt, loss;
		bit stopped;
		n = size_reg;
		if (n < 2)
			n = 2;
		if (n > GRID_CAP)
			n = GRID_CAP;
		// each edge step is one truncating divide by (n-1)
		step_top = (longint'(10) << FRAC) / (n - 1);
		step_left = (longint'(20) << FRAC) / (n - 1);
		for (y = 1; y + 1 < n; y++)
			for (x = 1; x + 1 < n; x++)
				grid_old[y*n+x] = 0;
		for (i = 0; i < n; i++) begin
			put_edge(i, (longint'(10) << FRAC) + step_top * i);
			put_edge(n*i, (longint'(10) << FRAC) + step_left * i);
			put_edge(n*(i+1) - 1, longint'(20) << FRAC);
			// bottom edge falls from 30 to 20
			put_edge(n*(n-1) + i, (longint'(30) << FRAC) - step_top * i);
		end
		loss = 0;
		stopped = 0;
		it = 0;
		while (!stopped && it < iter_limit_reg) begin
			for (y = 1; y + 1 < n; y++)
				for (x = 1; x + 1 < n; x++) begin
					s = grid_old[(y+1)*n+x] + grid_old[(y-1)*n+x]
						+ grid_old[y*n+x+1] + grid_old[y*n+x-1];
					grid_new[y*n+x] = s >> 2;
				end
			// change measured on the first, every 100th and the last iteration
			if (it % MEASURE_PERIOD == 0 || it + 1 == iter_limit_reg) begin
				loss = 0;
				for (y = 1; y + 1 < n; y++)
					for (x = 1; x + 1 < n; x++) begin
						a = grid_new[y*n+x];
						b = grid_old[y*n+x];
						dlt = a > b ? a - b : b - a;
						if (dlt > loss)
							loss = dlt;
					end
				if (loss <= accuracy_reg)
					stopped = 1;
			end
			if (!stopped) begin
				for (y = 1; y + 1 < n; y++)
					for (x = 1; x + 1 < n; x++)
						grid_old[y*n+x] = grid_new[y*n+x];
				it++;
			end
		end
		res.loss = loss[LOSS_W-1:0];
		res.iters = it[ITER_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// one start item; returns right after the accepting edge, valid left high
	task automatic send_start(input bit start);
		int gap;
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid = 1'b1;
		req.start_req = start;
		do @(posedge clk); while (!req.ready);
		if (start)
			pending_solves.push_back(run_relaxation());
	endtask

	// wait for the block to drain, then let a stray no-op item settle
	task automatic wait_idle();
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_solves.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		// shadow registers keep only the register's own width
		case (idx)
			REG_GRID_SIZE: size_reg = val[GRID_SIZE_W-1:0];
			REG_MAX_ITER:  iter_limit_reg = val[ITER_W-1:0];
			REG_ACCURACY:  accuracy_reg = val[LOSS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_solver(input int sz, input int lim, input int acc);
		wait_idle();
		write_reg(REG_GRID_SIZE, CFG_DATA_W'(sz));
		write_reg(REG_MAX_ITER, CFG_DATA_W'(lim));
		write_reg(REG_ACCURACY, CFG_DATA_W'(acc));
	endtask

	// sizes below 2 and above the grid capacity are clamped
	task automatic test_clamped_sizes();
		set_solver(0, 3, 0);
		send_start(1);
		set_solver(1, 3, 0);
		send_start(1);
		set_solver(127, 0, 0);
		send_start(1);
	endtask

	// a zero iteration limit gives zero change and zero iterations
	task automatic test_no_iterations();
		set_solver(5, 0, 24'hFFFFFF);
		send_start(1);
		send_start(1);
	endtask

	// side 2 has no interior, so it stops at once with zero change
	task automatic test_no_interior();
		set_solver(2, 20'hFFFFF, 0);
		send_start(1);
	endtask

	// accuracy at both ends: loosest stops on the first measure, tightest runs on
	task automatic test_accuracy_extremes();
		set_solver(6, 105, 24'hFFFFFF);
		send_start(1);
		set_solver(6, 105, 0);
		send_start(1);
		send_start(1);
	endtask

	// the full-size grid for a single iteration
	task automatic test_full_grid();
		set_solver(64, 1, 1);
		send_start(1);
	endtask

	// largest iteration limit on a single interior cell, which settles by iteration 100
	task automatic test_long_limit();
		set_solver(3, 20'hFFFFF, 0);
		send_start(1);
	endtask

	// items without a start bit produce nothing and are mixed with real ones
	task automatic test_idle_requests();
		set_solver(4, 7, 3);
		send_start(0);
		send_start(1);
		send_start(0);
		send_start(0);
		send_start(1);
	endtask

	// random settings per phase, random start items inside a phase
	task automatic test_random();
		int ph, k, sz, lim, acc, r;
		for (ph = 0; ph < 10; ph++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				// big grids only with a couple of iterations to keep the run short
				sz = $urandom_range(10, 127);
				lim = $urandom_range(0, 2);
			end else begin
				sz = $urandom_range(0, 9);
				lim = $urandom_range(0, 130);
			end
			case ($urandom_range(0, 2))
				0: acc = 0;
				1: acc = $urandom_range(0, 4096);
				default: acc = $urandom_range(0, 24'hFFFFFF);
			endcase
			set_solver(sz, lim, acc);
			for (k = 0; k < 10; k++)
				send_start($urandom_range(0, 9) != 0);
		end
	endtask

	// response side: random stalls of varying length
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_ready > 0) begin
				hold_ready--;
			end else if ($urandom_range(0, 3) == 0) begin
				rsp.ready = 1'b0;
				hold_ready = gap_len();
			end else begin
				rsp.ready = 1'b1;
			end
		end
	end

	// result checker against the oldest pending solve
	always @(posedge clk) begin
		solve_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_solves.size() == 0) begin
				report_mismatch("unexpected result, loss", rsp.final_loss, 0);
			end else begin
				want = pending_solves.pop_front();
				if (rsp.final_loss !== want.loss)
					report_mismatch("final_loss", rsp.final_loss, want.loss);
				if (rsp.iterations_done !== want.iters)
					report_mismatch("iterations_done", rsp.iterations_done, want.iters);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_jacobi_heat_grid_solver_unit NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_clamped_sizes();
		test_no_iterations();
		test_no_interior();
		test_accuracy_extremes();
		test_full_grid();
		test_long_limit();
		test_idle_requests();
		test_random();

		// drain and let the last item settle
		wait_idle();
		if (pending_solves.size() != 0)
			report_mismatch("solves left over", pending_solves.size(), 0);
		if (errors == 0)
			$display("tb_jacobi_heat_grid_solver_unit OK");
		else
			$display("tb_jacobi_heat_grid_solver_unit NOT OK");
		$finish;
	end

endmodule
